FILE: rtl/core/dtds_pkg.sv
// Package: shared constants, widths and the month table for the date-time difference block.
`timescale 1ns / 1ps
`default_nettype none
package dtds_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int DIFF_W  = 39;

    // floor(x / 100) = (x * 5243) >> 19, exact for x below 43690
    localparam int          DIV100_SHIFT = 19;
    localparam logic [12:0] DIV100_RECIP = 13'd5243;
    localparam int          Q100_W       = 8;    // quotient never above 164

    localparam int DBM_W   = 9;    // days before month, up to 334
    localparam int LEAPS_W = 13;   // leap years before year, up to about 4000
    localparam int DAYS_W  = 23;   // day ordinal, below 6.0e6
    localparam int TOD_W   = 17;   // seconds within a (possibly overlong) day

    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [16:0] SECS_PER_MIN  = 17'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;

    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;

    // Cumulative days before a month in a common year; month 0 acts as
    // January, months 13..15 act as December.
    function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
        logic [DBM_W-1:0] dbm;
        case (month) inside
            4'd0, 4'd1:           dbm = 9'd0;
            4'd2:                 dbm = 9'd31;
            4'd3:                 dbm = 9'd59;
            4'd4:                 dbm = 9'd90;
            4'd5:                 dbm = 9'd120;
            4'd6:                 dbm = 9'd151;
            4'd7:                 dbm = 9'd181;
            4'd8:                 dbm = 9'd212;
            4'd9:                 dbm = 9'd243;
            4'd10:                dbm = 9'd273;
            4'd11:                dbm = 9'd304;
            [4'd12:4'd15]:        dbm = 9'd334;
            default:              dbm = 9'd0;
        endcase
        return dbm;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/dtds_stamp.sv
// Four-stage pipeline mapping one date-time to a linear count of seconds.
`timescale 1ns / 1ps
`default_nettype none
module dtds_stamp (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic [dtds_pkg::YEAR_W-1:0]  year,
    input  wire logic [dtds_pkg::MONTH_W-1:0] month,
    input  wire logic [dtds_pkg::DAY_W-1:0]   day,
    input  wire logic [dtds_pkg::HOUR_W-1:0]  hour,
    input  wire logic [dtds_pkg::MIN_W-1:0]   minute,
    input  wire logic [dtds_pkg::SEC_W-1:0]   sec,
    output logic                              out_valid,
    output logic [dtds_pkg::DIFF_W-1:0]       seconds
);
    import dtds_pkg::*;

    // ---- stage 1: divide-by-100 products, month lookup, time of day
    logic [YEAR_W:0]       y_plus99;
    logic [27:0]           prod_ceil;
    logic [27:0]           prod_floor;
    logic                  s1_valid_reg;
    logic [YEAR_W-1:0]     s1_year_reg;
    logic [Q100_W-1:0]     s1_qceil_reg;
    logic [Q100_W-1:0]     s1_qfloor_reg;
    logic [DBM_W-1:0]      s1_dbm_reg;
    logic                  s1_late_reg;
    logic [DAY_W-1:0]      s1_day_reg;
    logic [TOD_W-1:0]      s1_tod_reg;
    logic [TOD_W-1:0]      tod_next;

    assign y_plus99   = (YEAR_W+1)'(year) + (YEAR_W+1)'(99);
    assign prod_ceil  = 28'(y_plus99) * 28'(DIV100_RECIP);
    assign prod_floor = 28'(year) * 28'(DIV100_RECIP);
    assign tod_next   = TOD_W'(hour) * SECS_PER_HOUR + TOD_W'(minute) * SECS_PER_MIN
                      + TOD_W'(sec);

    // ---- stage 2: leap count, leap flag, 365*y
    logic                  leap;
    logic [LEAPS_W-1:0]    leaps_next;
    logic                  s2_valid_reg;
    logic [DAYS_W-1:0]     s2_y365_reg;
    logic [LEAPS_W-1:0]    s2_leaps_reg;
    logic [DBM_W:0]        s2_md_reg;
    logic                  s2_adj_reg;
    logic [TOD_W-1:0]      s2_tod_reg;

    // y%100 == 0 exactly when ceil and floor quotients agree
    assign leap = ((s1_year_reg[1:0] == 2'b00) && (s1_qceil_reg != s1_qfloor_reg))
               || ((s1_qceil_reg == s1_qfloor_reg) && (s1_qfloor_reg[1:0] == 2'b00));
    // ceil(y/4) - ceil(y/100) + ceil(y/400), the last from the ceil(y/100)
    assign leaps_next = LEAPS_W'((YEAR_W+1)'(s1_year_reg) + (YEAR_W+1)'(3) >> 2)
                      - LEAPS_W'(s1_qceil_reg)
                      + LEAPS_W'(((Q100_W+1)'(s1_qceil_reg) + (Q100_W+1)'(3)) >> 2);

    // ---- stage 3: day ordinal
    logic                  s3_valid_reg;
    logic [DAYS_W-1:0]     s3_days_reg;
    logic [TOD_W-1:0]      s3_tod_reg;

    // ---- stage 4: seconds
    logic                  s4_valid_reg;
    logic [DIFF_W-1:0]     s4_secs_reg;
    logic [39:0]           day_secs;

    assign day_secs = 40'(s3_days_reg) * 40'(SECS_PER_DAY);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_year_reg   <= year;
        s1_qceil_reg  <= prod_ceil[DIV100_SHIFT+Q100_W-1:DIV100_SHIFT];
        s1_qfloor_reg <= prod_floor[DIV100_SHIFT+Q100_W-1:DIV100_SHIFT];
        s1_dbm_reg    <= days_before_month(month);
        s1_late_reg   <= (month > MONTH_FEB);
        s1_day_reg    <= day;
        s1_tod_reg    <= tod_next;

        s2_y365_reg   <= DAYS_W'(s1_year_reg) * DAYS_W'(DAYS_PER_YEAR);
        s2_leaps_reg  <= leaps_next;
        s2_md_reg     <= (DBM_W+1)'(s1_dbm_reg) + (DBM_W+1)'(s1_day_reg);
        s2_adj_reg    <= s1_late_reg & leap;
        s2_tod_reg    <= s1_tod_reg;

        s3_days_reg   <= s2_y365_reg + DAYS_W'(s2_leaps_reg) + DAYS_W'(s2_md_reg)
                       + DAYS_W'(s2_adj_reg);
        s3_tod_reg    <= s2_tod_reg;

        s4_secs_reg   <= day_secs[DIFF_W-1:0] + DIFF_W'(s3_tod_reg);
    end

    assign out_valid = s4_valid_reg;
    assign seconds   = s4_secs_reg;

endmodule
`default_nettype wire

FILE: rtl/core/dtds_absdiff.sv
// Output stage: registered magnitude of the difference of two second counts.
`timescale 1ns / 1ps
`default_nettype none
module dtds_absdiff (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    input  wire logic [dtds_pkg::DIFF_W-1:0] a,
    input  wire logic [dtds_pkg::DIFF_W-1:0] b,
    output logic                             out_valid,
    output logic [dtds_pkg::DIFF_W-1:0]      diff
);
    import dtds_pkg::*;

    logic                valid_reg;
    logic [DIFF_W-1:0]   diff_reg;
    logic [DIFF_W-1:0]   diff_next;

    assign diff_next = (a >= b) ? (a - b) : (b - a);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        diff_reg <= diff_next;
    end

    assign out_valid = valid_reg;
    assign diff      = diff_reg;

endmodule
`default_nettype wire

FILE: rtl/core/date_time_difference_seconds.sv
// Top level: absolute difference in seconds between two Gregorian date-times.
// Path: a request accepted at a clock edge is registered through both stamp pipelines
//   and the absdiff register, then shows its result on diff_seconds with done high.
// Throughput: one request per cycle; busy is always low and results cannot stall.
// Reset: rst_n clears only the valid bits of the pipeline; no done after reset.
`timescale 1ns / 1ps
`default_nettype none
module date_time_difference_seconds (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [dtds_pkg::YEAR_W-1:0]  first_year,
    input  wire logic [dtds_pkg::MONTH_W-1:0] first_month,
    input  wire logic [dtds_pkg::DAY_W-1:0]   first_day,
    input  wire logic [dtds_pkg::HOUR_W-1:0]  first_hour,
    input  wire logic [dtds_pkg::MIN_W-1:0]   first_minute,
    input  wire logic [dtds_pkg::SEC_W-1:0]   first_second,
    input  wire logic [dtds_pkg::YEAR_W-1:0]  second_year,
    input  wire logic [dtds_pkg::MONTH_W-1:0] second_month,
    input  wire logic [dtds_pkg::DAY_W-1:0]   second_day,
    input  wire logic [dtds_pkg::HOUR_W-1:0]  second_hour,
    input  wire logic [dtds_pkg::MIN_W-1:0]   second_minute,
    input  wire logic [dtds_pkg::SEC_W-1:0]   second_sec,
    output logic                              done,
    output logic [dtds_pkg::DIFF_W-1:0]       diff_seconds
);
    import dtds_pkg::*;

    // Every stage advances every cycle, so a request is never refused.
    logic                accept;
    logic                valid_a;
    logic                valid_b;
    logic [DIFF_W-1:0]   secs_a;
    logic [DIFF_W-1:0]   secs_b;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Stage 1..4: each stamp becomes
    //   (365*y + leaps before y + days before month + leap day + day) * 86400
    //   + hour*3600 + minute*60 + second
    dtds_stamp u_stamp_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .year      (first_year),
        .month     (first_month),
        .day       (first_day),
        .hour      (first_hour),
        .minute    (first_minute),
        .sec       (first_second),
        .out_valid (valid_a),
        .seconds   (secs_a)
    );

    dtds_stamp u_stamp_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .year      (second_year),
        .month     (second_month),
        .day       (second_day),
        .hour      (second_hour),
        .minute    (second_minute),
        .sec       (second_sec),
        .out_valid (valid_b),
        .seconds   (secs_b)
    );

    // Stage 5: magnitude of the difference, registered onto the result ports.
    dtds_absdiff u_absdiff (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (valid_a & valid_b),
        .a         (secs_a),
        .b         (secs_b),
        .out_valid (done),
        .diff      (diff_seconds)
    );

`ifndef SYNTHESIS
    // Both stamp pipelines must stay in lockstep.
    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        valid_a == valid_b)
        else $error("stamp pipelines out of step");

    // Every accepted request yields a done strobe.
    a_request_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted request produced no result");

    // Identical stamps give zero.
    a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && first_year == second_year && first_month == second_month
         && first_day == second_day && first_hour == second_hour
         && first_minute == second_minute && first_second == second_sec)
        |-> ##5 (diff_seconds == '0))
        else $error("equal stamps gave nonzero difference");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for date_time_difference_seconds: random and directed stamp pairs vs. a predictor.
`timescale 1ns / 1ps
module tb_top;

    import dtds_pkg::*;

    // Watchdog: cycles with neither a request taken nor a result seen.
    localparam int WATCHDOG_LIMIT = 4000;
    // Extra wait after the last result, so that stray strobes can show up.
    localparam int DRAIN_CYCLES   = 12;
    localparam longint unsigned DIFF_MASK = (64'd1 << DIFF_W) - 64'd1;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   sec;
    } date_stamp_t;

    // One request: the two stamps whose distance is wanted.
    typedef struct packed {
        date_stamp_t a;
        date_stamp_t b;
    } stamp_pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        done;
    logic [DIFF_W-1:0] diff_seconds;
    stamp_pair_t drive_req = '0;

    stamp_pair_t        pending_reqs[$];
    logic [DIFF_W-1:0]  expected_diffs[$];
    int                 idle_pct = 0;
    int                 reqs_queued = 0;
    int                 reqs_accepted = 0;
    int                 mismatches = 0;
    int                 quiet_cycles = 0;
    logic               req_taken = 1'b0;

    date_time_difference_seconds dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .first_year    (drive_req.a.year),
        .first_month   (drive_req.a.month),
        .first_day     (drive_req.a.day),
        .first_hour    (drive_req.a.hour),
        .first_minute  (drive_req.a.minute),
        .first_second  (drive_req.a.sec),
        .second_year   (drive_req.b.year),
        .second_month  (drive_req.b.month),
        .second_day    (drive_req.b.day),
        .second_hour   (drive_req.b.hour),
        .second_minute (drive_req.b.minute),
        .second_sec    (drive_req.b.sec),
        .done          (done),
        .diff_seconds  (diff_seconds)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: each stamp becomes a linear second count since year 0.
    // ------------------------------------------------------------------
    function automatic bit leap_year(input longint unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic longint unsigned linear_seconds(input date_stamp_t s);
        longint unsigned cum_days[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
        longint unsigned y;
        longint unsigned days;
        int              m;
        y = s.year;
        m = s.month;
        // Month 0 behaves as January, months 13..15 as December.
        if (m < 1)
            m = 1;
        if (m > 12)
            m = 12;
        // Leap years strictly before y, Gregorian rule.
        days = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        days += cum_days[m - 1];
        if (m > 2 && leap_year(y))
            days += 1;
        // Out-of-range day, hour, minute and second all just count on linearly.
        days += s.day;
        return days * 86400 + longint'(s.hour) * 3600 + longint'(s.minute) * 60 + s.sec;
    endfunction

    function automatic logic [DIFF_W-1:0] seconds_between(input stamp_pair_t p);
        longint unsigned ta;
        longint unsigned tb;
        ta = linear_seconds(p.a);
        tb = linear_seconds(p.b);
        return (ta >= tb) ? DIFF_W'((ta - tb) & DIFF_MASK) : DIFF_W'((tb - ta) & DIFF_MASK);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic date_stamp_t make_stamp(input int y, input int mo, input int d,
                                               input int h, input int mi, input int s);
        date_stamp_t t;
        t.year   = YEAR_W'(y);
        t.month  = MONTH_W'(mo);
        t.day    = DAY_W'(d);
        t.hour   = HOUR_W'(h);
        t.minute = MIN_W'(mi);
        t.sec    = SEC_W'(s);
        return t;
    endfunction

    // full_width: every bit of every field is random, out-of-range values included.
    function automatic date_stamp_t random_stamp(input bit full_width);
        int          notable[10] = '{0, 1, 4, 100, 399, 400, 1900, 2000, 2024, 9999};
        date_stamp_t t;
        if (full_width)
        begin
            t.year   = YEAR_W'($urandom);
            t.month  = MONTH_W'($urandom);
            t.day    = DAY_W'($urandom);
            t.hour   = HOUR_W'($urandom);
            t.minute = MIN_W'($urandom);
            t.sec    = SEC_W'($urandom);
        end
        else
        begin
            // Century and leap boundaries get picked more often than chance.
            t.year   = ($urandom_range(99) < 25) ? YEAR_W'(notable[$urandom_range(9)])
                                                 : YEAR_W'($urandom_range(9999));
            t.month  = MONTH_W'($urandom_range(12, 1));
            t.day    = DAY_W'($urandom_range(31, 1));
            t.hour   = HOUR_W'($urandom_range(23));
            t.minute = MIN_W'($urandom_range(59));
            t.sec    = SEC_W'($urandom_range(59));
        end
        return t;
    endfunction

    task automatic queue_request(input date_stamp_t a, input date_stamp_t b);
        stamp_pair_t p;
        p.a = a;
        p.b = b;
        pending_reqs.push_back(p);
        reqs_queued++;
    endtask

    task automatic queue_random(input int count);
        date_stamp_t a;
        date_stamp_t b;
        int          pick;
        repeat (count)
        begin
            pick = $urandom_range(99);
            a = random_stamp(1'b0);
            b = random_stamp(1'b0);
            if (pick < 15)
            begin
                // Close pair: small or zero distance, maybe across a boundary.
                b = a;
                case ($urandom_range(3))
                    0: b.sec    = a.sec + SEC_W'($urandom_range(2));
                    1: b.minute = a.minute + MIN_W'($urandom_range(1));
                    2: b.day    = a.day + DAY_W'($urandom_range(2));
                    default: ;
                endcase
            end
            else if (pick < 30)
                a = random_stamp(1'b1);
            else if (pick < 45)
                b = random_stamp(1'b1);
            else if (pick < 55)
            begin
                a = random_stamp(1'b1);
                b = random_stamp(1'b1);
            end
            queue_request(a, b);
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: presents the next request at the falling edge, holds it
    // until it has been taken, and idles at random between requests.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (!rst_n)
            start <= 1'b0;
        else if (!start || req_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                drive_req <= pending_reqs.pop_front();
                start     <= 1'b1;
            end
            else
                start <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: logs taken requests and checks each result against the
    // oldest outstanding prediction.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            req_taken <= 1'b0;
        else
        begin
            req_taken <= start && !busy;
            if (start && !busy)
            begin
                expected_diffs.push_back(seconds_between(drive_req));
                reqs_accepted <= reqs_accepted + 1;
            end
            if (done)
            begin
                if (expected_diffs.size() == 0)
                begin
                    $error("diff_seconds: expected none, got %0d", diff_seconds);
                    mismatches <= mismatches + 1;
                end
                else if (expected_diffs[0] !== diff_seconds)
                begin
                    $error("diff_seconds: expected %0d, got %0d",
                           expected_diffs[0], diff_seconds);
                    mismatches <= mismatches + 1;
                    void'(expected_diffs.pop_front());
                end
                else
                    void'(expected_diffs.pop_front());
            end
        end
    end

    // Watchdog: a hung pipeline or a lost result ends the run here.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: reset, directed requests, then random phases with
    // different sender idle rates.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Phase 1: back-to-back requests, directed cases first.
        idle_pct = 0;
        queue_request(make_stamp(2000, 2, 29, 12, 34, 56), make_stamp(2000, 2, 29, 12, 34, 56));
        queue_request(make_stamp(0, 0, 0, 0, 0, 0), make_stamp(0, 0, 0, 0, 0, 0));
        queue_request(make_stamp(0, 1, 1, 0, 0, 0), make_stamp(9999, 12, 31, 23, 59, 59));
        queue_request(make_stamp(9999, 12, 31, 23, 59, 59), make_stamp(0, 1, 1, 0, 0, 0));
        // Century rule: 1900 common, 2000 leap, 12000 leap.
        queue_request(make_stamp(1900, 2, 28, 0, 0, 0), make_stamp(1900, 3, 1, 0, 0, 0));
        queue_request(make_stamp(2000, 2, 28, 0, 0, 0), make_stamp(2000, 3, 1, 0, 0, 0));
        queue_request(make_stamp(12000, 2, 29, 1, 2, 3), make_stamp(12000, 3, 1, 1, 2, 3));
        // Day past month end rolls into the next month.
        queue_request(make_stamp(2023, 2, 29, 0, 0, 0), make_stamp(2023, 3, 1, 0, 0, 0));
        queue_request(make_stamp(2023, 2, 30, 7, 0, 0), make_stamp(2023, 3, 2, 7, 0, 0));
        queue_request(make_stamp(2023, 1, 31, 0, 0, 0), make_stamp(2023, 4, 31, 0, 0, 0));
        // Day zero is the last day of the previous month.
        queue_request(make_stamp(2024, 3, 0, 0, 0, 0), make_stamp(2024, 2, 29, 0, 0, 0));
        // Month zero acts as January, 13..15 as December.
        queue_request(make_stamp(2024, 0, 15, 0, 0, 0), make_stamp(2024, 1, 15, 0, 0, 0));
        queue_request(make_stamp(2024, 13, 5, 0, 0, 0), make_stamp(2024, 15, 5, 0, 0, 0));
        queue_request(make_stamp(2024, 12, 5, 0, 0, 1), make_stamp(2024, 14, 5, 0, 0, 0));
        // Time-of-day fields past range count on.
        queue_request(make_stamp(2024, 6, 10, 24, 0, 0), make_stamp(2024, 6, 11, 0, 0, 0));
        queue_request(make_stamp(2024, 6, 10, 10, 60, 60), make_stamp(2024, 6, 10, 11, 1, 0));
        queue_request(make_stamp(2024, 6, 10, 31, 63, 63), make_stamp(2024, 6, 10, 0, 0, 0));
        // Year rollover and year-zero leap handling.
        queue_request(make_stamp(2023, 12, 31, 23, 59, 59), make_stamp(2024, 1, 1, 0, 0, 0));
        queue_request(make_stamp(1, 1, 1, 0, 0, 0), make_stamp(0, 12, 31, 0, 0, 0));
        queue_request(make_stamp(400, 3, 1, 0, 0, 0), make_stamp(399, 3, 1, 0, 0, 0));
        // Largest possible distance: every field at its maximum.
        queue_request(make_stamp(16383, 15, 31, 31, 63, 63), make_stamp(0, 0, 0, 0, 0, 0));
        queue_request(make_stamp(0, 0, 0, 0, 0, 0), make_stamp(16383, 15, 31, 31, 63, 63));
        queue_random(130);
        while (pending_reqs.size() != 0)
            @(posedge clk);

        // Phase 2: sender mostly idle.
        idle_pct = 80;
        queue_random(135);
        while (pending_reqs.size() != 0)
            @(posedge clk);

        // Phase 3: light sender idling.
        idle_pct = 23;
        queue_random(135);

        // Wait for all requests to be taken and answered, then let any
        // stray strobe show up before the verdict.
        while (reqs_accepted != reqs_queued || expected_diffs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
